// ----- hdl/tiny_isa_step_core_macros.svh -----
// Assertion macros used by the checker file tis_checker.
// No dependencies.
`ifndef TINY_ISA_STEP_CORE_MACROS_SVH
`define TINY_ISA_STEP_CORE_MACROS_SVH
// implication checked on every clock, disabled during reset
`define TIS_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("tis check failed");
// next-cycle implication
`define TIS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("tis check failed");
`endif

// ----- hdl/tis_pkg.sv -----
// Types and constants of the tiny ISA step core.
// No dependencies.
package tis_pkg;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;
    localparam logic [2:0] FLAG_GT = 3'b100;
    localparam logic [2:0] FLAG_LT = 3'b010;
    localparam logic [2:0] FLAG_EQ = 3'b001;
    localparam logic [3:0] OP_MOVI = 4'h0;
    localparam logic [3:0] OP_MOV  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_CMP  = 4'h4;
    localparam logic [3:0] OP_JMP  = 4'h5;
    localparam logic [3:0] OP_JGT  = 4'h6;
    localparam logic [3:0] OP_JLT  = 4'h7;
    localparam logic [3:0] OP_JEQ  = 4'h8;
    localparam logic [3:0] OP_ADD  = 4'h9;
    localparam logic [3:0] OP_SUB  = 4'ha;
    localparam logic [3:0] OP_AND  = 4'hb;
    localparam logic [3:0] OP_OR   = 4'hc;
    localparam logic [3:0] OP_XOR  = 4'hd;
    localparam logic [3:0] OP_SHL  = 4'he;
    localparam logic [3:0] OP_SAR  = 4'hf;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_REGRD,
        ST_EXEC,
        ST_LDRD,
        ST_STWR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        command;
        logic [6:0]  load_address;
        logic [7:0]  load_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] step_pc;
        logic [7:0]  opcode;
        logic [3:0]  dest_index;
        logic signed [31:0] dest_value;
        logic        reg_written;
        logic [2:0]  flags;
        logic [31:0] use_count;
        logic        slot_skipped;
        logic [31:0] next_pc;
        logic        halted;
    } out_item_t;
endpackage

// ----- hdl/tis_stream_if.sv -----
// Valid/ready channel carrying one payload type.
// No dependencies; the payload type is a parameter.
interface tis_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/tiny_isa_step_core.sv -----
// Tiny ISA step core: byte memory, register file, usage counters.
// Depends on tis_pkg and tis_stream_if.
//
// channel | dir | payload
// in_ch   | in  | command, load_address, load_byte
// out_ch  | out | step_pc, opcode, dest_index, dest_value, reg_written, flags, ...
//
// The result is offered after ST_OUT. A load or a halted step goes there straight
// from the input transfer; a step passes ST_FETCH (four byte reads), ST_REGRD (two
// register reads) and ST_EXEC first, then ST_LDRD for a memory load or ST_STWR for
// a store (four more byte reads or writes through the single-port byte memory).
// The next input is taken the cycle after the result transfer.
// After reset a clearing pass zeroes the byte memory; no item is taken meanwhile.
// One item is in flight; a stalled output holds.
module tiny_isa_step_core #(
    parameter int MEM_BYTES = 128
) (
    input  logic clk,
    input  logic rst_n,
    tis_stream_if.sink   in_ch,
    tis_stream_if.source out_ch
);
    localparam int AW = $clog2(MEM_BYTES);
    localparam int SLOTS = (MEM_BYTES + 3) / 4;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [7:0]  mem [MEM_BYTES];
    logic [31:0] rf [16];
    logic [31:0] uc [16];
    logic [SLOTS-1:0] exec_reg;
    logic [15:0] rfv_reg, ucv_reg;

    tis_pkg::state_t state_reg, state_next;
    tis_pkg::out_item_t res_reg;
    tis_pkg::out_item_t res_init;
    logic [AW:0]   clr_reg;
    logic [31:0]   pc_reg;
    logic [2:0]    flags_reg;
    logic [2:0]    cnt_reg;
    logic [31:0]   ins_reg;
    logic [31:0]   a_reg, b_reg, data_reg, uc_inc;
    logic [31:0]   rf_q, uc_q;
    logic [7:0]    mem_q;
    logic          out_valid_reg;

    // memory address and write controls
    logic [AW-1:0] maddr;
    logic          mwe;
    logic [7:0]    mwd;
    logic [31:0]   base;
    logic [31:0]   imm;
    logic [3:0]    op4, rx, ry;
    logic          op_ok;
    logic [SW-1:0] slot;
    logic [4:0]    shamt;

    assign op4   = ins_reg[3:0];
    assign op_ok = (ins_reg[7:4] == 4'h0);
    assign rx    = ins_reg[15:12];
    assign ry    = ins_reg[11:8];
    assign imm   = {{16{ins_reg[31]}}, ins_reg[31:16]};
    assign shamt = ins_reg[28:24];
    assign slot  = SW'((pc_reg >> 2) % SLOTS);

    always_comb
    begin
        base = pc_reg;
        if (state_reg == tis_pkg::ST_LDRD)
            base = b_reg;
        else if (state_reg == tis_pkg::ST_STWR)
            base = a_reg;
        maddr = AW'((base + 32'(cnt_reg[1:0])) % MEM_BYTES);
        mwe = 1'b0;
        mwd = b_reg[8*cnt_reg[1:0] +: 8];
        if (clr_reg != (AW+1)'(MEM_BYTES))
        begin
            maddr = clr_reg[AW-1:0];
            mwe = 1'b1;
            mwd = 8'h00;
        end
        else if (state_reg == tis_pkg::ST_IDLE && in_ch.valid && in_ch.ready &&
                 in_ch.data.command == tis_pkg::CMD_LOAD)
        begin
            maddr = AW'(32'(in_ch.data.load_address) % MEM_BYTES);
            mwe = 1'b1;
            mwd = in_ch.data.load_byte;
        end
        else if (state_reg == tis_pkg::ST_STWR)
            mwe = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
            mem[maddr] <= mwd;
        mem_q <= mem[maddr];
    end

    // register file and counters: one read each, registered
    logic [3:0] rf_ra;
    logic       rf_we, uc_we;
    logic [31:0] rf_wd;
    assign rf_ra = (state_reg == tis_pkg::ST_FETCH) ? rx : ry;
    always_ff @(posedge clk)
    begin
        rf_q <= rf[rf_ra];
        uc_q <= uc[op4];
        if (rf_we)
            rf[rx] <= rf_wd;
        if (uc_we)
            uc[op4] <= uc_inc;
    end

    assign in_ch.ready = (state_reg == tis_pkg::ST_IDLE) &&
                         (clr_reg == (AW+1)'(MEM_BYTES)) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tis_pkg::ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                    state_next = (in_ch.data.command == tis_pkg::CMD_STEP &&
                                  pc_reg < 32'(MEM_BYTES)) ? tis_pkg::ST_FETCH
                                                           : tis_pkg::ST_OUT;
            tis_pkg::ST_FETCH:
                if (cnt_reg == 3'd5) state_next = tis_pkg::ST_REGRD;
            tis_pkg::ST_REGRD:
                if (cnt_reg == 3'd1) state_next = tis_pkg::ST_EXEC;
            tis_pkg::ST_EXEC:
                if (!exec_reg[slot] && op_ok && op4 == tis_pkg::OP_LD)
                    state_next = tis_pkg::ST_LDRD;
                else if (!exec_reg[slot] && op_ok && op4 == tis_pkg::OP_ST)
                    state_next = tis_pkg::ST_STWR;
                else
                    state_next = tis_pkg::ST_OUT;
            tis_pkg::ST_LDRD:
                if (cnt_reg == 3'd4) state_next = tis_pkg::ST_OUT;
            tis_pkg::ST_STWR:
                if (cnt_reg == 3'd3) state_next = tis_pkg::ST_OUT;
            tis_pkg::ST_OUT:
                state_next = tis_pkg::ST_IDLE;
            default:
                state_next = tis_pkg::ST_IDLE;
        endcase
    end

    logic [31:0] a_eff, b_eff, uc_eff, res;
    logic        wr;
    logic [31:0] pc_add;
    logic [2:0]  fl_new;
    always_comb
    begin
        a_eff  = rfv_reg[rx] ? a_reg : 32'h0;
        b_eff  = rfv_reg[ry] ? b_reg : 32'h0;
        uc_eff = ucv_reg[op4] ? uc_q : 32'h0;
        uc_inc = (uc_eff == 32'hffffffff) ? uc_eff : uc_eff + 32'd1;
        res = 32'h0;
        wr = 1'b0;
        pc_add = 32'h0;
        fl_new = flags_reg;
        case (op4)
            tis_pkg::OP_MOVI: begin res = imm; wr = 1'b1; end
            tis_pkg::OP_MOV:  begin res = b_eff; wr = 1'b1; end
            tis_pkg::OP_LD:   wr = 1'b1;
            tis_pkg::OP_CMP:
                if ($signed(a_eff) > $signed(b_eff)) fl_new = tis_pkg::FLAG_GT;
                else if ($signed(a_eff) < $signed(b_eff)) fl_new = tis_pkg::FLAG_LT;
                else fl_new = tis_pkg::FLAG_EQ;
            tis_pkg::OP_JMP:  pc_add = imm;
            tis_pkg::OP_JGT:  if (flags_reg == tis_pkg::FLAG_GT) pc_add = imm;
            tis_pkg::OP_JLT:  if (flags_reg == tis_pkg::FLAG_LT) pc_add = imm;
            tis_pkg::OP_JEQ:  if (flags_reg == tis_pkg::FLAG_EQ) pc_add = imm;
            tis_pkg::OP_ADD:  begin res = a_eff + b_eff; wr = 1'b1; end
            tis_pkg::OP_SUB:  begin res = a_eff - b_eff; wr = 1'b1; end
            tis_pkg::OP_AND:  begin res = a_eff & b_eff; wr = 1'b1; end
            tis_pkg::OP_OR:   begin res = a_eff | b_eff; wr = 1'b1; end
            tis_pkg::OP_XOR:  begin res = a_eff ^ b_eff; wr = 1'b1; end
            tis_pkg::OP_SHL:  begin res = a_eff << shamt; wr = 1'b1; end
            tis_pkg::OP_SAR:  begin res = 32'($signed(a_eff) >>> shamt); wr = 1'b1; end
            default: ;
        endcase
        if (!op_ok)
        begin
            wr = 1'b0;
            pc_add = 32'h0;
            fl_new = flags_reg;
        end
    end

    // register write: ALU ops at EXEC, load at its end
    always_comb
    begin
        rf_we = 1'b0;
        rf_wd = res;
        if (state_reg == tis_pkg::ST_EXEC && !exec_reg[slot] && wr &&
            op4 != tis_pkg::OP_LD)
            rf_we = 1'b1;
        else if (state_reg == tis_pkg::ST_LDRD && cnt_reg == 3'd4)
        begin
            rf_we = 1'b1;
            rf_wd = {mem_q, data_reg[31:8]};
        end
        uc_we = (state_reg == tis_pkg::ST_EXEC) && op_ok;
    end

    // result fields known at the input transfer
    always_comb
    begin
        res_init = '0;
        if (in_ch.data.command == tis_pkg::CMD_STEP)
        begin
            res_init.step_pc = pc_reg;
            res_init.next_pc = pc_reg;
            res_init.flags   = flags_reg;
            res_init.halted  = !(pc_reg < 32'(MEM_BYTES));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tis_pkg::ST_IDLE;
            clr_reg       <= '0;
            pc_reg        <= '0;
            flags_reg     <= '0;
            exec_reg      <= '0;
            rfv_reg       <= '0;
            ucv_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_reg != (AW+1)'(MEM_BYTES))
                clr_reg <= clr_reg + 1'b1;
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == tis_pkg::ST_OUT)
                out_valid_reg <= 1'b1;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
            if (rf_we)
                rfv_reg[rx] <= 1'b1;
            if (uc_we)
                ucv_reg[op4] <= 1'b1;
            if (state_reg == tis_pkg::ST_EXEC)
            begin
                exec_reg[slot] <= 1'b1;
                if (!exec_reg[slot])
                    flags_reg <= fl_new;
                pc_reg <= pc_reg + (exec_reg[slot] ? 32'h0 : pc_add) + 32'd4;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tis_pkg::ST_IDLE && in_ch.valid && in_ch.ready)
            res_reg <= res_init;
        // fetch bytes arrive the cycle after their address
        if (state_reg == tis_pkg::ST_FETCH && cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            ins_reg <= {mem_q, ins_reg[31:8]};
        // drop never-written register contents to zero
        if (state_reg == tis_pkg::ST_REGRD && cnt_reg == 3'd0)
            a_reg <= rfv_reg[rx] ? rf_q : 32'h0;
        if (state_reg == tis_pkg::ST_REGRD && cnt_reg == 3'd1)
            b_reg <= rfv_reg[ry] ? rf_q : 32'h0;
        if (state_reg == tis_pkg::ST_LDRD && cnt_reg >= 3'd1)
            data_reg <= {mem_q, data_reg[31:8]};
        if (state_reg == tis_pkg::ST_EXEC)
        begin
            res_reg.opcode <= ins_reg[7:0];
            res_reg.use_count <= op_ok ? uc_inc : 32'h0;
            res_reg.slot_skipped <= exec_reg[slot];
            res_reg.flags <= exec_reg[slot] ? flags_reg : fl_new;
            res_reg.next_pc <= pc_reg + (exec_reg[slot] ? 32'h0 : pc_add) + 32'd4;
            if (!exec_reg[slot] && wr)
            begin
                res_reg.dest_index  <= rx;
                res_reg.dest_value  <= res;
                res_reg.reg_written <= 1'b1;
            end
        end
        if (state_reg == tis_pkg::ST_LDRD && cnt_reg == 3'd4)
            res_reg.dest_value <= {mem_q, data_reg[31:8]};
    end
endmodule

// ----- hdl/tis_checker.sv -----
// Port-level checks of the tiny ISA step core, bound to tiny_isa_step_core.
// Depends on tiny_isa_step_core_macros.svh.
`include "tiny_isa_step_core_macros.svh"
module tis_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic halted,
    input logic reg_written,
    input logic slot_skipped
);
    // one item in flight: no new transfer while a result waits
    `TIS_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
    `TIS_ASSERT_IMPL(a_halt_no_write, clk, rst_n, out_valid && halted, !reg_written)
    `TIS_ASSERT_IMPL(a_skip_no_write, clk, rst_n, out_valid && slot_skipped, !reg_written)
    `TIS_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind tiny_isa_step_core tis_checker u_tis_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .halted(out_ch.data.halted),
    .reg_written(out_ch.data.reg_written),
    .slot_skipped(out_ch.data.slot_skipped)
);

// ----- test/tb_tiny_isa_step_core.sv -----
// Testbench for tiny_isa_step_core: directed rows, then random programs.
// Depends on tis_pkg, tis_stream_if and the core itself.
module tb_tiny_isa_step_core;
    typedef struct {
        logic      cmd;
        logic [6:0] addr;
        logic [7:0] bval;
        bit        typed;
        tis_pkg::out_item_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 18;
    localparam int MEMB = 128;

    logic clk;
    logic rst_n;

    tis_stream_if #(.payload_t(tis_pkg::in_item_t))  in_ch();
    tis_stream_if #(.payload_t(tis_pkg::out_item_t)) out_ch();

    tiny_isa_step_core #(.MEM_BYTES(MEMB)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    // shadow machine state
    logic [7:0]  mem_img [MEMB];
    logic [31:0] regs [16];
    logic [31:0] op_uses [16];
    bit          slot_done [32];
    logic [2:0]  cur_flags;
    logic [31:0] cur_pc;

    tis_pkg::out_item_t expected_steps [$];
    dir_row_t  dir_tab [DIR_ROWS];
    int err_count = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_exec = 0;
    int n_skip = 0;
    int n_halt = 0;
    int n_load = 0;
    bit all_sent = 0;
    bit held_off = 0;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb_tiny_isa_step_core: done, errors");
        $finish;
    end

    function automatic logic [7:0] mem_at(logic [31:0] a);
        return mem_img[a % MEMB];
    endfunction

    function automatic tis_pkg::out_item_t predict_step(tis_pkg::in_item_t it);
        tis_pkg::out_item_t r;
        logic [31:0] pc, imm, a, b, res, ld;
        logic [7:0] op, regs_byte, imm_lo, imm_hi;
        logic [3:0] rx, ry;
        logic [4:0] sh;
        int slot;
        bit wr;
        r = '0;
        wr = 0;
        res = 0;
        if (it.command == tis_pkg::CMD_LOAD)
        begin
            mem_img[it.load_address] = it.load_byte;
            n_load++;
            return r;
        end
        pc = cur_pc;
        r.step_pc = pc;
        r.next_pc = pc;
        r.flags = cur_flags;
        if (pc >= MEMB)
        begin
            r.halted = 1;
            n_halt++;
            return r;
        end
        op = mem_at(pc);
        regs_byte = mem_at(pc + 1);
        rx = regs_byte[7:4];
        ry = regs_byte[3:0];
        imm_lo = mem_at(pc + 2);
        imm_hi = mem_at(pc + 3);
        imm = {{16{imm_hi[7]}}, imm_hi, imm_lo};
        r.opcode = op;
        if (op < 16)
        begin
            if (op_uses[op] != 32'hffff_ffff)
                op_uses[op]++;
            r.use_count = op_uses[op];
        end
        slot = (pc / 4) % 32;
        if (slot_done[slot])
        begin
            r.slot_skipped = 1;
            cur_pc = pc + 4;
            r.next_pc = cur_pc;
            n_skip++;
            return r;
        end
        slot_done[slot] = 1;
        n_exec++;
        a = regs[rx];
        b = regs[ry];
        sh = imm[12:8];
        if (op < 16)
        begin
            case (op[3:0])
                tis_pkg::OP_MOVI: begin res = imm; wr = 1; end
                tis_pkg::OP_MOV:  begin res = b; wr = 1; end
                tis_pkg::OP_LD:
                begin
                    ld = {mem_at(b + 3), mem_at(b + 2), mem_at(b + 1), mem_at(b)};
                    res = ld;
                    wr = 1;
                end
                tis_pkg::OP_ST:
                    for (int k = 0; k < 4; k++)
                        mem_img[(a + k) % MEMB] = 8'(b >> (8 * k));
                tis_pkg::OP_CMP:
                    if ($signed(a) > $signed(b))
                        cur_flags = tis_pkg::FLAG_GT;
                    else if ($signed(a) < $signed(b))
                        cur_flags = tis_pkg::FLAG_LT;
                    else
                        cur_flags = tis_pkg::FLAG_EQ;
                tis_pkg::OP_JMP: pc = pc + imm;
                tis_pkg::OP_JGT: if (cur_flags == tis_pkg::FLAG_GT) pc = pc + imm;
                tis_pkg::OP_JLT: if (cur_flags == tis_pkg::FLAG_LT) pc = pc + imm;
                tis_pkg::OP_JEQ: if (cur_flags == tis_pkg::FLAG_EQ) pc = pc + imm;
                tis_pkg::OP_ADD: begin res = a + b; wr = 1; end
                tis_pkg::OP_SUB: begin res = a - b; wr = 1; end
                tis_pkg::OP_AND: begin res = a & b; wr = 1; end
                tis_pkg::OP_OR:  begin res = a | b; wr = 1; end
                tis_pkg::OP_XOR: begin res = a ^ b; wr = 1; end
                tis_pkg::OP_SHL: begin res = a << sh; wr = 1; end
                tis_pkg::OP_SAR: begin res = $signed(a) >>> sh; wr = 1; end
                default: ;
            endcase
        end
        if (wr)
        begin
            regs[rx] = res;
            r.dest_index = rx;
            r.dest_value = res;
            r.reg_written = 1;
        end
        cur_pc = pc + 4;
        r.flags = cur_flags;
        r.next_pc = cur_pc;
        return r;
    endfunction

    function automatic int send_idle_pct();
        if (n_sent < 240)
            return 11;
        else if (n_sent < 480)
            return 74;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_sent < 240)
            return 74;
        else if (n_sent < 480)
            return 11;
        return 0;
    endfunction

    // append one expected result at the tail of the queue
    task automatic queue_expect(tis_pkg::out_item_t e);
        expected_steps.insert(expected_steps.size(), e);
    endtask

    // offer one item and hold it until the transfer
    task automatic offer_item(tis_pkg::in_item_t it, bit use_typed,
                              tis_pkg::out_item_t typed_out);
        tis_pkg::out_item_t p;
        p = predict_step(it);
        queue_expect(use_typed ? typed_out : p);
        while ($urandom_range(99) < send_idle_pct())
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.data <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n_sent++;
    endtask

    task automatic offer_plain(logic cmd, logic [31:0] addr, logic [7:0] bval);
        tis_pkg::in_item_t it;
        it.command = cmd;
        it.load_address = addr[6:0];
        it.load_byte = bval;
        offer_item(it, 0, '0);
    endtask

    // write four instruction bytes at the current pc, then step
    task automatic run_instr(logic [7:0] op, logic [3:0] rx, logic [3:0] ry, logic [15:0] imm);
        logic [31:0] at;
        at = cur_pc;
        offer_plain(tis_pkg::CMD_LOAD, at, op);
        offer_plain(tis_pkg::CMD_LOAD, at + 1, {rx, ry});
        offer_plain(tis_pkg::CMD_LOAD, at + 2, imm[7:0]);
        offer_plain(tis_pkg::CMD_LOAD, at + 3, imm[15:8]);
        offer_plain(tis_pkg::CMD_STEP, 0, 0);
    endtask

    task automatic put_row(int i, logic cmd, logic [6:0] addr, logic [7:0] bval,
                           bit typed, tis_pkg::out_item_t want);
        dir_tab[i].cmd = cmd;
        dir_tab[i].addr = addr;
        dir_tab[i].bval = bval;
        dir_tab[i].typed = typed;
        dir_tab[i].want = want;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got %h want %h", n_recv, what, got, want);
        err_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // receiver: check each transfer, pace ready, one long hold-off
    initial
    begin
        tis_pkg::out_item_t e, g;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                g = out_ch.data;
                if (expected_steps.size() == 0)
                    report_mismatch("unexpected result", 0, 0);
                else
                begin
                    e = expected_steps.pop_front();
                    check_field("step_pc", g.step_pc, e.step_pc);
                    check_field("opcode", 32'(g.opcode), 32'(e.opcode));
                    check_field("dest_index", 32'(g.dest_index), 32'(e.dest_index));
                    check_field("dest_value", g.dest_value, e.dest_value);
                    check_field("reg_written", 32'(g.reg_written), 32'(e.reg_written));
                    check_field("flags", 32'(g.flags), 32'(e.flags));
                    check_field("use_count", g.use_count, e.use_count);
                    check_field("slot_skipped", 32'(g.slot_skipped), 32'(e.slot_skipped));
                    check_field("next_pc", g.next_pc, e.next_pc);
                    check_field("halted", 32'(g.halted), 32'(e.halted));
                end
                n_recv++;
            end
            if (!held_off && n_sent >= 490)
            begin
                held_off = 1;
                out_ch.ready <= 0;
                repeat (300) @(posedge clk);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    initial
    begin
        int waited;
        int kind;
        logic [7:0] op;
        logic [15:0] imm;
        logic [31:0] tgt;
        for (int i = 0; i < MEMB; i++)
            mem_img[i] = 0;
        for (int i = 0; i < 16; i++)
        begin
            regs[i] = 0;
            op_uses[i] = 0;
        end
        for (int i = 0; i < 32; i++)
            slot_done[i] = 0;
        cur_flags = 0;
        cur_pc = 0;

        // step on cleared memory runs move-immediate r0 = 0 at pc 0
        put_row(0, tis_pkg::CMD_STEP, 7'd0, 8'h00, 1,
                '{32'd0, 8'd0, 4'd0, 32'sd0, 1'b1, 3'd0, 32'd1, 1'b0, 32'd4, 1'b0});
        put_row(1, tis_pkg::CMD_LOAD, 7'd127, 8'hff, 1, '0);
        put_row(2, tis_pkg::CMD_LOAD, 7'd4, {4'h0, tis_pkg::OP_MOVI}, 1, '0);
        put_row(3, tis_pkg::CMD_LOAD, 7'd5, 8'h10, 1, '0);
        put_row(4, tis_pkg::CMD_LOAD, 7'd6, 8'h00, 1, '0);
        put_row(5, tis_pkg::CMD_LOAD, 7'd7, 8'h80, 1, '0);
        put_row(6, tis_pkg::CMD_STEP, 7'd0, 8'h00, 0, '0);
        put_row(7, tis_pkg::CMD_LOAD, 7'd8, {4'h0, tis_pkg::OP_SAR}, 1, '0);
        put_row(8, tis_pkg::CMD_LOAD, 7'd9, 8'h10, 1, '0);
        put_row(9, tis_pkg::CMD_LOAD, 7'd10, 8'h00, 1, '0);
        put_row(10, tis_pkg::CMD_LOAD, 7'd11, 8'hff, 1, '0);
        put_row(11, tis_pkg::CMD_STEP, 7'd0, 8'h00, 0, '0);
        put_row(12, tis_pkg::CMD_LOAD, 7'd12, {4'h0, tis_pkg::OP_SHL}, 1, '0);
        put_row(13, tis_pkg::CMD_LOAD, 7'd13, 8'h11, 1, '0);
        put_row(14, tis_pkg::CMD_LOAD, 7'd14, 8'h00, 1, '0);
        put_row(15, tis_pkg::CMD_LOAD, 7'd15, 8'h1f, 1, '0);
        put_row(16, tis_pkg::CMD_STEP, 7'd0, 8'h00, 0, '0);
        put_row(17, tis_pkg::CMD_LOAD, 7'd0, 8'h00, 1, '0);

        rst_n = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            tis_pkg::in_item_t it;
            it.command = dir_tab[i].cmd;
            it.load_address = dir_tab[i].addr;
            it.load_byte = dir_tab[i].bval;
            offer_item(it, dir_tab[i].typed, dir_tab[i].want);
        end

        // random programs: mostly well-formed instructions, some noise
        while (n_sent < 680)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                op = ($urandom_range(99) < 5) ? 8'($urandom_range(16, 255))
                                              : 8'($urandom_range(0, 15));
                imm = 16'($urandom);
                if (op >= tis_pkg::OP_JMP && op <= tis_pkg::OP_JEQ)
                begin
                    // keep the jump target inside memory
                    tgt = $urandom_range(0, 31) * 4;
                    if ($urandom_range(9) == 0)
                        tgt = tgt + $urandom_range(1, 3) - 4;
                    if (tgt >= MEMB)
                        tgt = 0;
                    imm = 16'(tgt - cur_pc - 4);
                end
                run_instr(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), imm);
            end
            else if (kind < 90)
                offer_plain(tis_pkg::CMD_LOAD, $urandom, 8'($urandom));
            else
                offer_plain(tis_pkg::CMD_STEP, $urandom, 8'($urandom));
        end

        // jump out of memory so the machine halts, then step it a few times
        for (int i = 0; i < 8; i++)
            run_instr({4'h0, tis_pkg::OP_JMP}, 4'h0, 4'h0, 16'h7000);
        for (int i = 0; i < 6; i++)
            offer_plain(tis_pkg::CMD_STEP, 0, 0);

        in_ch.valid <= 0;
        all_sent = 1;
        waited = 0;
        while (expected_steps.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (30) @(posedge clk);
        if (expected_steps.size() != 0)
        begin
            $display("%0d results never arrived", expected_steps.size());
            err_count++;
        end
        $display("covered %0d transfers in: %0d loads, %0d executed, %0d skipped, %0d halted",
                 n_sent, n_load, n_exec, n_skip, n_halt);
        $display("%0d results checked, %0d mismatches", n_recv, err_count);
        if (err_count == 0)
            $display("tb_tiny_isa_step_core: done, clean");
        else
            $display("tb_tiny_isa_step_core: done, errors");
        $finish;
    end
endmodule
